FILE: rtl/mtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 generator package
// Sizes, command codes, recurrence constants and the word functions shared
// by the generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

    // store geometry
    localparam int STATE_WORDS = 624;
    localparam int TAP_OFFSET  = 397;
    localparam int KEY_DEPTH   = 16;

    localparam int WORD_W    = 32;
    localparam int MODE_W    = 2;
    localparam int ADDR_W    = $clog2(STATE_WORDS);
    localparam int IDX_W     = $clog2(STATE_WORDS + 2);
    localparam int KEY_IDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KEY_CNT_W = $clog2(KEY_DEPTH + 1);

    // command codes
    localparam logic [MODE_W-1:0] MODE_DRAW = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEY  = 2'd2;

    // recurrence constants
    localparam logic [WORD_W-1:0] MUL_SEED     = 32'd1812433253;
    localparam logic [WORD_W-1:0] MUL_KEY_ADD  = 32'd1664525;
    localparam logic [WORD_W-1:0] MUL_KEY_MIX  = 32'd1566083941;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
    localparam logic [WORD_W-1:0] ARRAY_SEED   = 32'd19650218;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

    typedef logic [WORD_W-1:0] t_word;

    // fold the top bits down before the seeding multiply
    function automatic t_word fold_word(input t_word p);
        return p ^ (p >> 30);
    endfunction

    // one twist step on the current, next and tap words
    function automatic t_word mix_word(input t_word a, input t_word b, input t_word tap);
        t_word y;
        y = (a & HIGH_BIT) | (b & LOW_BITS);
        return tap ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
    endfunction

    // output tempering
    function automatic t_word temper_word(input t_word w);
        t_word y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

FILE: rtl/mersenne_twister_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 generator
// Draw: the word is read into r_rd_a with r_dv set, then tempered into
//   o_random_word with o_strobe; one draw a cycle while the store holds
//   unused words. Draw on an exhausted store: busy for the twist pass (one
//   word a cycle, two read ports and one write port of the state memory).
// Seed: busy for the linear seed pass; key scramble: busy after the last key
//   word for seed and mixing passes; a first draw after reset adds a default seed.
// Reset: synchronous, active low; store unseeded, key store empty, the
//   state memory is not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [mtg_pkg::MODE_W-1:0] i_mode,
    input  logic [mtg_pkg::WORD_W-1:0] i_value,
    input  logic                       i_key_last,
    output logic                       o_strobe,
    output logic [mtg_pkg::WORD_W-1:0] o_random_word
);
    import mtg_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LIN    = 4'd1;
    localparam logic [3:0] S_PASS1  = 4'd2;
    localparam logic [3:0] S_PASS2  = 4'd3;
    localparam logic [3:0] S_FLUSH  = 4'd4;
    localparam logic [3:0] S_FIX    = 4'd5;
    localparam logic [3:0] S_TPRIME = 4'd6;
    localparam logic [3:0] S_TWIST  = 4'd7;
    localparam logic [3:0] S_TFLUSH = 4'd8;

    // what follows the linear seed
    localparam logic [1:0] AFTER_IDLE  = 2'd0;
    localparam logic [1:0] AFTER_TWIST = 2'd1;
    localparam logic [1:0] AFTER_KEY   = 2'd2;

    // write stage operations
    localparam logic [1:0] OP_P1 = 2'd0;
    localparam logic [1:0] OP_P2 = 2'd1;
    localparam logic [1:0] OP_TW = 2'd2;

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] P2_LAST    = ADDR_W'(STATE_WORDS - 2);
    localparam logic [ADDR_W-1:0] TAP_WRAP   = ADDR_W'(STATE_WORDS - TAP_OFFSET);
    localparam logic [IDX_W-1:0]  IDX_FRESH  = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0]  IDX_UNSEED = IDX_W'(STATE_WORDS + 1);

    // memories
    t_word r_mem     [0:STATE_WORDS-1];
    t_word r_key_mem [0:KEY_DEPTH-1];

    // control registers
    logic [3:0]           r_state, n_state;
    logic [1:0]           r_after;
    logic [ADDR_W-1:0]    r_cnt, n_cnt;
    logic [ADDR_W-1:0]    r_i;
    logic [KEY_IDX_W-1:0] r_j;
    logic [KEY_CNT_W-1:0] r_len;
    logic [IDX_W-1:0]     r_read_index;
    logic [KEY_CNT_W-1:0] r_key_count;
    logic                 r_wv;
    logic                 r_dv;

    // datapath registers
    logic [1:0]           r_wop;
    logic [ADDR_W-1:0]    r_waddr;
    logic [KEY_IDX_W-1:0] r_wj;
    t_word                r_prev;
    t_word                r_cur;
    t_word                r_rd_a;
    t_word                r_rd_b;
    t_word                r_rd_key;

    // combinational signals
    logic                 accept;
    logic                 draw_now;
    logic                 key_room;
    logic [KEY_CNT_W-1:0] key_cnt_inc;
    logic [KEY_CNT_W-1:0] key_len;
    logic [ADDR_W-1:0]    next_addr;
    logic [ADDR_W-1:0]    tap_addr;
    logic [ADDR_W-1:0]    i_adv;
    logic [KEY_IDX_W-1:0] j_adv;
    logic                 rd_a_en;
    logic [ADDR_W-1:0]    rd_a_addr;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    t_word                wdata;
    t_word                mul_k;
    t_word                prod;
    logic                 counting;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign draw_now = accept && (i_mode == MODE_DRAW) && (r_read_index < IDX_FRESH);

    // key store bookkeeping
    assign key_room    = (r_key_count < KEY_CNT_W'(KEY_DEPTH));
    assign key_cnt_inc = r_key_count + (key_room ? KEY_CNT_W'(1) : KEY_CNT_W'(0));
    assign key_len     = (key_cnt_inc == '0) ? KEY_CNT_W'(1) : key_cnt_inc;

    // twist neighbors and pass index advance
    assign next_addr = (r_cnt == LAST_ADDR) ? '0 : r_cnt + ADDR_W'(1);
    assign tap_addr  = (r_cnt < TAP_WRAP) ? r_cnt + ADDR_W'(TAP_OFFSET) : r_cnt - TAP_WRAP;
    assign i_adv     = (r_i == LAST_ADDR) ? ADDR_W'(1) : r_i + ADDR_W'(1);
    assign j_adv     = ((KEY_CNT_W'(r_j) + KEY_CNT_W'(1)) == r_len) ? '0
                     : r_j + KEY_IDX_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_DRAW: begin
                            if (r_read_index == IDX_UNSEED) begin
                                n_state = S_LIN;
                            end else if (r_read_index == IDX_FRESH) begin
                                n_state = S_TPRIME;
                            end
                        end
                        MODE_SEED: n_state = S_LIN;
                        MODE_KEY: begin
                            if (i_key_last) begin
                                n_state = S_LIN;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LIN: begin
                if (r_cnt == LAST_ADDR) begin
                    case (r_after)
                        AFTER_TWIST: n_state = S_TPRIME;
                        AFTER_KEY:   n_state = S_PASS1;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_PASS1:  if (r_cnt == LAST_ADDR) n_state = S_PASS2;
            S_PASS2:  if (r_cnt == P2_LAST) n_state = S_FLUSH;
            S_FLUSH:  n_state = S_FIX;
            S_FIX:    n_state = S_IDLE;
            S_TPRIME: n_state = S_TWIST;
            S_TWIST:  if (r_cnt == LAST_ADDR) n_state = S_TFLUSH;
            S_TFLUSH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // step counter restarts on each state change
    assign counting = (r_state == S_LIN) || (r_state == S_PASS1) ||
                      (r_state == S_PASS2) || (r_state == S_TWIST);
    assign n_cnt    = (counting && (n_state == r_state)) ? r_cnt + ADDR_W'(1) : '0;

    // read port A address
    always_comb begin
        rd_a_en   = 1'b0;
        rd_a_addr = '0;
        case (r_state)
            S_IDLE: begin
                rd_a_en   = draw_now;
                rd_a_addr = r_read_index[ADDR_W-1:0];
            end
            S_TPRIME, S_TFLUSH: rd_a_en = 1'b1;
            S_TWIST: begin
                rd_a_en   = 1'b1;
                rd_a_addr = next_addr;
            end
            S_PASS1, S_PASS2: begin
                rd_a_en   = 1'b1;
                rd_a_addr = r_i;
            end
            default: rd_a_en = 1'b0;
        endcase
    end

    // shared multiplier on the folded previous word
    assign mul_k = (r_state == S_LIN) ? MUL_SEED
                 : (r_wop == OP_P2)   ? MUL_KEY_MIX : MUL_KEY_ADD;
    assign prod  = fold_word(r_prev) * mul_k;

    // write port: linear seed, write stage, or final word fixup
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (r_state == S_LIN) begin
            we    = 1'b1;
            waddr = r_cnt;
            wdata = (r_cnt == '0) ? r_prev : prod + WORD_W'(r_cnt);
        end else if (r_wv) begin
            we    = 1'b1;
            waddr = r_waddr;
            case (r_wop)
                OP_P1:   wdata = (r_rd_a ^ prod) + r_rd_key + WORD_W'(r_wj);
                OP_P2:   wdata = (r_rd_a ^ prod) - WORD_W'(r_waddr);
                OP_TW:   wdata = mix_word(r_cur, r_rd_a, r_rd_b);
                default: wdata = '0;
            endcase
        end else if (r_state == S_FIX) begin
            we    = 1'b1;
            wdata = HIGH_BIT;
        end
    end

    // state memory: one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_a_en) begin
            r_rd_a <= r_mem[rd_a_addr];
        end
        if (r_state == S_TWIST) begin
            r_rd_b <= r_mem[tap_addr];
        end
    end

    // key memory: write on transfer, registered read during the first pass
    always_ff @(posedge i_clk) begin
        if (accept && (i_mode == MODE_KEY) && key_room) begin
            r_key_mem[r_key_count[KEY_IDX_W-1:0]] <= i_value;
        end
        if (r_state == S_PASS1) begin
            r_rd_key <= r_key_mem[r_j];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_read_index <= IDX_UNSEED;
            r_key_count  <= '0;
            r_wv         <= 1'b0;
            r_dv         <= 1'b0;
            o_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_wv     <= (r_state == S_PASS1) || (r_state == S_PASS2) ||
                        (r_state == S_TWIST);
            r_dv     <= draw_now || (r_state == S_TFLUSH);
            o_strobe <= r_dv;

            // advance the read index; a twist, a seed or a final key word sets it anew
            if (r_state == S_TFLUSH) begin
                r_read_index <= IDX_W'(1);
            end else if (draw_now) begin
                r_read_index <= r_read_index + IDX_W'(1);
            end else if (accept && ((i_mode == MODE_SEED) ||
                                    ((i_mode == MODE_KEY) && i_key_last))) begin
                r_read_index <= IDX_FRESH;
            end

            // count key words, drop the count after the scramble starts
            if (accept && (i_mode == MODE_KEY)) begin
                r_key_count <= i_key_last ? '0 : key_cnt_inc;
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        // capture the command
        if (accept) begin
            case (i_mode)
                MODE_DRAW: begin
                    r_prev  <= DEFAULT_SEED;
                    r_after <= AFTER_TWIST;
                end
                MODE_SEED: begin
                    r_prev  <= i_value;
                    r_after <= AFTER_IDLE;
                end
                MODE_KEY: begin
                    r_prev  <= ARRAY_SEED;
                    r_after <= AFTER_KEY;
                    r_len   <= key_len;
                end
                default: r_after <= AFTER_IDLE;
            endcase
        end

        // chain the previous word through the recurrences
        if (r_state == S_LIN) begin
            if ((r_cnt == LAST_ADDR) && (r_after == AFTER_KEY)) begin
                r_prev <= ARRAY_SEED;
            end else if (r_cnt != '0) begin
                r_prev <= wdata;
            end
        end else if (r_wv && (r_wop != OP_TW)) begin
            r_prev <= wdata;
        end

        // pass indexes
        if (r_state == S_LIN) begin
            r_i <= ADDR_W'(1);
            r_j <= '0;
        end else if ((r_state == S_PASS1) || (r_state == S_PASS2)) begin
            r_i <= i_adv;
            r_j <= j_adv;
        end

        // load the write stage
        r_wj    <= r_j;
        r_waddr <= (r_state == S_TWIST) ? r_cnt : r_i;
        case (r_state)
            S_PASS2: r_wop <= OP_P2;
            S_TWIST: r_wop <= OP_TW;
            default: r_wop <= OP_P1;
        endcase

        // hold the current twist word
        if ((r_state == S_TWIST) || (r_wv && (r_wop == OP_TW))) begin
            r_cur <= r_rd_a;
        end

        // temper the drawn word
        if (r_dv) begin
            o_random_word <= temper_word(r_rd_a);
        end
    end

endmodule

FILE: verif/tb_mersenne_twister_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT19937 generator testbench
// Drives draw, seed and key-load commands through the start/busy handshake
// and predicts every tempered word with an in-bench copy of the generator
// state. Words are checked in order as they strobe out. Covers the unseeded
// draw, seed extremes, short, partial and overflowing keys, store exhaustion
// across a twist, and a random mix with idle bursts.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_generator_top;

    import mtg_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int DRAIN_LIMIT = 4000;
    localparam int TAIL_CYCLES = 8;
    localparam int MIX_TARGET  = 1580;

    // unused command code: the block must ignore it
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [MODE_W-1:0] i_mode;
    logic [WORD_W-1:0] i_value;
    logic              i_key_last;
    logic              o_strobe;
    logic [WORD_W-1:0] o_random_word;

    mersenne_twister_generator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_value       (i_value),
        .i_key_last    (i_key_last),
        .o_strobe      (o_strobe),
        .o_random_word (o_random_word)
    );

    // generator state as predicted
    t_word       mt_state [0:STATE_WORDS-1];
    int unsigned mt_index;
    t_word       key_words [0:KEY_DEPTH-1];
    int unsigned key_held;

    // tempered words awaiting their strobe
    t_word       pending_words [$];
    t_word       word_due;

    bit          idle_enabled;
    int          fail_count;
    int          cycle_count;
    int          items_sent;
    int          draws_sent;
    int          seeds_sent;
    int          key_words_sent;
    int          key_words_dropped;
    int          scrambles_run;
    int          twists_run;
    int          words_checked;

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // fill the store from one word with the linear recurrence
    function automatic void seed_store(input t_word s);
        t_word p;
        mt_state[0] = s;
        for (int i = 1; i < STATE_WORDS; i++) begin
            p = mt_state[i-1];
            mt_state[i] = MUL_SEED * (p ^ (p >> 30)) + 32'(i);
        end
        mt_index = STATE_WORDS;
    endfunction

    // init-by-array scramble over the held key words
    function automatic void scramble_key(input int unsigned len);
        int unsigned row;
        int unsigned col;
        int unsigned passes;
        t_word       p;
        t_word       m;
        seed_store(ARRAY_SEED);
        if (len == 0) len = 1;
        if (len > KEY_DEPTH) len = KEY_DEPTH;
        passes = (len > STATE_WORDS) ? len : STATE_WORDS;
        row = 1;
        col = 0;
        for (int k = 0; k < passes; k++) begin
            p = mt_state[row-1];
            m = (p ^ (p >> 30)) * MUL_KEY_ADD;
            mt_state[row] = (mt_state[row] ^ m) + key_words[col] + 32'(col);
            row++;
            col++;
            if (row >= STATE_WORDS) begin
                mt_state[0] = mt_state[STATE_WORDS-1];
                row = 1;
            end
            if (col >= len) col = 0;
        end
        for (int k = 0; k < STATE_WORDS - 1; k++) begin
            p = mt_state[row-1];
            m = (p ^ (p >> 30)) * MUL_KEY_MIX;
            mt_state[row] = (mt_state[row] ^ m) - 32'(row);
            row++;
            if (row >= STATE_WORDS) begin
                mt_state[0] = mt_state[STATE_WORDS-1];
                row = 1;
            end
        end
        mt_state[0] = HIGH_BIT;
        mt_index = STATE_WORDS;
    endfunction

    // regenerate the whole store in place
    function automatic void twist_store();
        t_word a;
        t_word b;
        t_word tap;
        t_word y;
        for (int n = 0; n < STATE_WORDS; n++) begin
            a   = mt_state[n];
            b   = mt_state[(n + 1) % STATE_WORDS];
            tap = mt_state[(n + TAP_OFFSET) % STATE_WORDS];
            y   = {a[WORD_W-1], b[WORD_W-2:0]};
            mt_state[n] = tap ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'h0);
        end
        mt_index = 0;
    endfunction

    function automatic t_word temper_out(input t_word w);
        t_word t;
        t = w ^ (w >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        return t ^ (t >> 18);
    endfunction

    // advance the predicted state by one command; return 1 when a word is due
    function automatic bit predict_command(input logic [MODE_W-1:0] mode,
                                           input t_word value, input logic last,
                                           output t_word word);
        word = '0;
        case (mode)
            MODE_DRAW: begin
                if (mt_index > STATE_WORDS) seed_store(DEFAULT_SEED);
                if (mt_index >= STATE_WORDS) begin
                    twist_store();
                    twists_run++;
                end
                word = temper_out(mt_state[mt_index]);
                mt_index++;
                return 1'b1;
            end
            MODE_SEED: begin
                seed_store(value);
            end
            MODE_KEY: begin
                if (key_held < KEY_DEPTH) begin
                    key_words[key_held] = value;
                    key_held++;
                end else begin
                    key_words_dropped++;
                end
                if (last) begin
                    scramble_key(key_held);
                    key_held = 0;
                    scrambles_run++;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic t_word pick_word();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 32'h0;
        if (sel == 1) return 32'hffff_ffff;
        return $urandom;
    endfunction

    // transfer one command, with an optional idle burst ahead of it
    task automatic send_command(input logic [MODE_W-1:0] mode, input t_word value,
                                input logic last);
        int    gap;
        t_word word;
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                start   = 1'b0;
                i_value = $urandom;
            end
        end
        @(negedge i_clk);
        start      = 1'b1;
        i_mode     = mode;
        i_value    = value;
        i_key_last = last;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        case (mode)
            MODE_DRAW: draws_sent++;
            MODE_SEED: seeds_sent++;
            MODE_KEY:  key_words_sent++;
            default: ;
        endcase
        if (predict_command(mode, value, last, word)) pending_words.push_back(word);
    endtask

    task automatic send_draws(input int count);
        for (int i = 0; i < count; i++) send_command(MODE_DRAW, $urandom, 1'($urandom));
    endtask

    // load a whole key, the final word marked last
    task automatic send_key(input int len);
        for (int i = 0; i < len; i++) send_command(MODE_KEY, pick_word(), i == len - 1);
    endtask

    task automatic test_unseeded_draw();
        send_command(MODE_DRAW, 32'hffff_ffff, 1'b1);
        send_command(MODE_DRAW, 32'h0, 1'b0);
        send_command(MODE_NONE, 32'hffff_ffff, 1'b1);
        send_command(MODE_DRAW, 32'h0, 1'b0);
    endtask

    task automatic test_seed_extremes();
        send_command(MODE_SEED, 32'h0, 1'b1);
        send_command(MODE_DRAW, 32'h0, 1'b0);
        send_command(MODE_DRAW, 32'hffff_ffff, 1'b1);
        send_command(MODE_SEED, 32'hffff_ffff, 1'b0);
        send_command(MODE_DRAW, 32'h0, 1'b0);
        send_command(MODE_DRAW, 32'h0, 1'b0);
    endtask

    task automatic test_single_word_key();
        send_command(MODE_KEY, 32'h0, 1'b1);
        send_command(MODE_DRAW, 32'h0, 1'b0);
        send_command(MODE_KEY, 32'hffff_ffff, 1'b1);
        send_command(MODE_DRAW, 32'h0, 1'b0);
    endtask

    // a seed in the middle of a key load leaves the partial key in place
    task automatic test_seed_during_key();
        send_command(MODE_KEY, 32'h0123_4567, 1'b0);
        send_command(MODE_KEY, 32'h89ab_cdef, 1'b0);
        send_command(MODE_SEED, 32'h0000_0001, 1'b0);
        send_command(MODE_DRAW, 32'h0, 1'b0);
        send_command(MODE_KEY, 32'hffff_ffff, 1'b1);
        send_command(MODE_DRAW, 32'h0, 1'b0);
    endtask

    // words past the key depth are dropped; the scramble uses the full depth
    task automatic test_key_overflow();
        send_key(KEY_DEPTH + 3);
        send_draws(4);
    endtask

    // run far enough past one seed to exhaust the store a second time
    task automatic test_store_exhaustion();
        send_command(MODE_SEED, pick_word(), 1'b0);
        send_draws(STATE_WORDS + 16);
    endtask

    task automatic test_random_mix();
        int pick;
        while (items_sent < MIX_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_draws($urandom_range(1, 40));
            end else if (pick < 67) begin
                send_command(MODE_SEED, pick_word(), 1'($urandom));
                send_draws($urandom_range(1, 6));
            end else if (pick < 82) begin
                send_key($urandom_range(1, KEY_DEPTH + 4));
                send_draws($urandom_range(1, 8));
            end else if (pick < 92) begin
                // noise: unused code, or marks that the block must ignore
                if ($urandom_range(0, 1))
                    send_command(MODE_NONE, $urandom, 1'($urandom));
                else
                    send_command(MODE_SEED, $urandom, 1'b1);
                send_draws($urandom_range(0, 3));
            end else begin
                // broken key: words with no last mark, then something else
                for (int i = $urandom_range(1, 5); i > 0; i--)
                    send_command(MODE_KEY, pick_word(), 1'b0);
                if ($urandom_range(0, 1)) send_command(MODE_SEED, pick_word(), 1'b0);
                send_draws($urandom_range(1, 5));
            end
        end
    endtask

    // the last stretch runs with start held high and no idling
    task automatic test_back_to_back();
        idle_enabled = 1'b0;
        send_draws(40);
        send_command(MODE_SEED, pick_word(), 1'b0);
        send_draws(10);
        send_key(2);
        send_draws(20);
    endtask

    // check each strobed word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            words_checked++;
            if (pending_words.size() == 0) begin
                $error("random_word: no word expected, actual %h", o_random_word);
                fail_count++;
            end else begin
                word_due = pending_words.pop_front();
                if (o_random_word !== word_due) begin
                    $error("random_word: expected %h, actual %h", word_due, o_random_word);
                    fail_count++;
                end
            end
        end
    end

    // abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_mersenne_twister_generator_top failed");
            $finish;
        end
    end

    initial begin
        int waited;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_mode       = MODE_DRAW;
        i_value      = '0;
        i_key_last   = 1'b0;
        idle_enabled = 1'b1;
        fail_count   = 0;
        cycle_count  = 0;
        mt_index     = STATE_WORDS + 1;
        key_held     = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_unseeded_draw();
        test_seed_extremes();
        test_single_word_key();
        test_seed_during_key();
        test_key_overflow();
        test_store_exhaustion();
        test_random_mix();
        test_back_to_back();

        // drop start and let the last words come out
        @(negedge i_clk);
        start = 1'b0;
        waited = 0;
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            $error("random_word: %0d expected words never arrived", pending_words.size());
            fail_count++;
        end

        $display("commands: %0d (%0d draws, %0d seeds, %0d key words, %0d dropped)",
                 items_sent, draws_sent, seeds_sent, key_words_sent, key_words_dropped);
        $display("key scrambles: %0d, store twists: %0d, words checked: %0d",
                 scrambles_run, twists_run, words_checked);
        if (fail_count == 0) begin
            $display("tb_mersenne_twister_generator_top passed");
        end else begin
            $display("tb_mersenne_twister_generator_top failed");
        end
        $finish;
    end

endmodule
